[hw/rtl/vtic_pkg.sv]
// shared types and constants for the volume table insert block
// geometry constants, status codes, control word and flag structs
// no dependencies
package vtic_pkg;

  // disk geometry and table size
  localparam int SECTORS_PER_CYLINDER = 16;
  localparam int CYLINDERS            = 16;
  localparam int MAX_VOLUMES          = 8;
  localparam int CAPACITY             = SECTORS_PER_CYLINDER * CYLINDERS;

  // field widths
  localparam int CYL_W   = 4;
  localparam int SEC_W   = 4;
  localparam int CNT_W   = 8;
  localparam int SLOT_W  = 3;
  localparam int VOLS_W  = 4;
  localparam int ENTRY_W = CYL_W + SEC_W + CNT_W;
  // linear sector position, end of an extent may run past the disk
  localparam int POS_W   = $clog2(2 * CAPACITY);

  // program counter width
  localparam int PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_CREATED = 2'd0,
    ST_INVALID = 2'd1,
    ST_OVERLAP = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // jump conditions, a true condition takes the jump
  typedef enum logic [2:0] {
    CC_NEVER,
    CC_ALWAYS,
    CC_NO_INPUT,
    CC_ARG_BAD,
    CC_FULL,
    CC_SCAN_DONE,
    CC_NO_OVERLAP,
    CC_OUT_BUSY
  } cond_t;

  // one microcode word
  typedef struct packed {
    logic    accept;      // offer in_tready, load request on transaction
    logic    clr_scan;    // clear scan index and slot
    logic    rd;          // read table at scan index
    logic    inc_idx;     // advance scan index
    logic    wr;          // append request at the next free slot
    logic    load_out;    // move result to the output register
    logic    set_status;  // load status register from status field
    status_t status;
    cond_t   cond;
    pc_t     target;
  } ctrl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic arg_bad;
    logic full;
    logic scan_done;
    logic overlap;
    logic out_busy;
  } flags_t;

endpackage

[hw/rtl/vtic_seq.sv]
// microcode sequencer: program counter, control store and jump logic
// depends on vtic_pkg
module vtic_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  vtic_pkg::flags_t flags,
  output vtic_pkg::ctrl_t  ctrl
);

  // program step addresses
  localparam vtic_pkg::pc_t PC_FETCH  = 3'd0;
  localparam vtic_pkg::pc_t PC_ARGS   = 3'd1;
  localparam vtic_pkg::pc_t PC_ROOM   = 3'd2;
  localparam vtic_pkg::pc_t PC_READ   = 3'd3;
  localparam vtic_pkg::pc_t PC_CMP    = 3'd4;
  localparam vtic_pkg::pc_t PC_HIT    = 3'd5;
  localparam vtic_pkg::pc_t PC_INSERT = 3'd6;
  localparam vtic_pkg::pc_t PC_REPORT = 3'd7;

  vtic_pkg::pc_t pc_r;
  vtic_pkg::pc_t pc_nxt;
  logic          take;

  // control store
  function automatic vtic_pkg::ctrl_t rom(input vtic_pkg::pc_t pc);
    vtic_pkg::ctrl_t w;
    w = '0;
    w.status = vtic_pkg::ST_CREATED;
    w.cond   = vtic_pkg::CC_NEVER;
    w.target = PC_FETCH;
    unique case (pc)
      PC_FETCH: begin
        w.accept = 1'b1;
        w.cond   = vtic_pkg::CC_NO_INPUT;
        w.target = PC_FETCH;
      end
      PC_ARGS: begin
        w.clr_scan   = 1'b1;
        w.set_status = 1'b1;
        w.status     = vtic_pkg::ST_INVALID;
        w.cond       = vtic_pkg::CC_ARG_BAD;
        w.target     = PC_REPORT;
      end
      PC_ROOM: begin
        w.set_status = 1'b1;
        w.status     = vtic_pkg::ST_FULL;
        w.cond       = vtic_pkg::CC_FULL;
        w.target     = PC_REPORT;
      end
      PC_READ: begin
        w.rd         = 1'b1;
        w.set_status = 1'b1;
        w.status     = vtic_pkg::ST_OVERLAP;
        w.cond       = vtic_pkg::CC_SCAN_DONE;
        w.target     = PC_INSERT;
      end
      PC_CMP: begin
        w.inc_idx = 1'b1;
        w.cond    = vtic_pkg::CC_NO_OVERLAP;
        w.target  = PC_READ;
      end
      PC_HIT: begin
        w.cond   = vtic_pkg::CC_ALWAYS;
        w.target = PC_REPORT;
      end
      PC_INSERT: begin
        w.wr         = 1'b1;
        w.set_status = 1'b1;
        w.status     = vtic_pkg::ST_CREATED;
      end
      PC_REPORT: begin
        // fall-through wraps to the fetch step
        w.load_out = 1'b1;
        w.cond     = vtic_pkg::CC_OUT_BUSY;
        w.target   = PC_REPORT;
      end
      default: begin
        w.cond   = vtic_pkg::CC_ALWAYS;
        w.target = PC_FETCH;
      end
    endcase
    return w;
  endfunction

  assign ctrl = rom(pc_r);

  // condition select
  always_comb begin
    unique case (ctrl.cond)
      vtic_pkg::CC_NEVER:      take = 1'b0;
      vtic_pkg::CC_ALWAYS:     take = 1'b1;
      vtic_pkg::CC_NO_INPUT:   take = !flags.in_valid;
      vtic_pkg::CC_ARG_BAD:    take = flags.arg_bad;
      vtic_pkg::CC_FULL:       take = flags.full;
      vtic_pkg::CC_SCAN_DONE:  take = flags.scan_done;
      vtic_pkg::CC_NO_OVERLAP: take = !flags.overlap;
      vtic_pkg::CC_OUT_BUSY:   take = flags.out_busy;
      default:                 take = 1'b0;
    endcase
  end

  assign pc_nxt = take ? ctrl.target : pc_r + vtic_pkg::pc_t'(1);

  // program counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

[hw/rtl/vtic_dp.sv]
// datapath: request registers, volume table memory, extent compare, result register
// depends on vtic_pkg
module vtic_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  vtic_pkg::ctrl_t               ctrl,
  output vtic_pkg::flags_t              flags,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [vtic_pkg::CYL_W-1:0]    first_cylinder,
  input  logic [vtic_pkg::SEC_W-1:0]    first_sector,
  input  logic [vtic_pkg::CNT_W-1:0]    sector_count,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output vtic_pkg::status_t             status,
  output logic [vtic_pkg::SLOT_W-1:0]   slot_index,
  output logic [vtic_pkg::VOLS_W-1:0]   volume_count
);

  localparam int POS_W = vtic_pkg::POS_W;

  // request registers
  logic [vtic_pkg::CYL_W-1:0]   req_cyl_r;
  logic [vtic_pkg::SEC_W-1:0]   req_sec_r;
  logic [vtic_pkg::CNT_W-1:0]   req_cnt_r;
  // table state
  logic [vtic_pkg::ENTRY_W-1:0] mem [vtic_pkg::MAX_VOLUMES];
  logic [vtic_pkg::ENTRY_W-1:0] rd_data_r;
  logic [vtic_pkg::VOLS_W-1:0]  vols_r;
  logic [vtic_pkg::VOLS_W-1:0]  idx_r;
  logic [vtic_pkg::SLOT_W-1:0]  slot_r;
  vtic_pkg::status_t            status_r;
  // result register
  logic                         out_valid_r;
  vtic_pkg::status_t            out_status_r;
  logic [vtic_pkg::SLOT_W-1:0]  out_slot_r;
  logic [vtic_pkg::VOLS_W-1:0]  out_vols_r;

  logic                         accept;
  logic                         out_busy;
  logic [vtic_pkg::CYL_W-1:0]   old_cyl;
  logic [vtic_pkg::SEC_W-1:0]   old_sec;
  logic [vtic_pkg::CNT_W-1:0]   old_cnt;
  logic [POS_W-1:0]             new_start;
  logic [POS_W-1:0]             new_end;
  logic [POS_W-1:0]             old_start;
  logic [POS_W-1:0]             old_end;

  assign in_tready = ctrl.accept;
  assign accept    = ctrl.accept && in_tvalid;
  assign out_busy  = out_valid_r && !out_tready;

  // extents as linear sector positions
  assign {old_cnt, old_sec, old_cyl} = rd_data_r;
  assign new_start = POS_W'(req_cyl_r) * POS_W'(vtic_pkg::SECTORS_PER_CYLINDER)
                   + POS_W'(req_sec_r);
  assign new_end   = new_start + POS_W'(req_cnt_r) - POS_W'(1);
  assign old_start = POS_W'(old_cyl) * POS_W'(vtic_pkg::SECTORS_PER_CYLINDER)
                   + POS_W'(old_sec);
  assign old_end   = old_start + POS_W'(old_cnt) - POS_W'(1);

  // flags for the sequencer
  always_comb begin
    flags.in_valid  = in_tvalid;
    flags.arg_bad   = (req_cyl_r == '0)
                   || (32'(req_cyl_r) >= 32'(vtic_pkg::CYLINDERS))
                   || (req_sec_r == '0)
                   || (32'(req_sec_r) >= 32'(vtic_pkg::SECTORS_PER_CYLINDER))
                   || (req_cnt_r == '0)
                   || (32'(req_cnt_r) >= 32'(vtic_pkg::CAPACITY));
    flags.full      = 32'(vols_r) >= 32'(vtic_pkg::MAX_VOLUMES);
    flags.scan_done = idx_r == vols_r;
    flags.overlap   = !(((new_start < old_start) && (new_end < old_start))
                     || (old_end < new_start));
    flags.out_busy  = out_busy;
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_cyl_r <= first_cylinder;
      req_sec_r <= first_sector;
      req_cnt_r <= sector_count;
    end
  end

  // volume table memory
  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      mem[vols_r[vtic_pkg::SLOT_W-1:0]] <= {req_cnt_r, req_sec_r, req_cyl_r};
    end
    if (ctrl.rd) begin
      rd_data_r <= mem[idx_r[vtic_pkg::SLOT_W-1:0]];
    end
  end

  // scan index, slot, status and volume count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vols_r   <= '0;
      idx_r    <= '0;
      slot_r   <= '0;
      status_r <= vtic_pkg::ST_CREATED;
    end else begin
      if (ctrl.clr_scan) begin
        idx_r  <= '0;
        slot_r <= '0;
      end else if (ctrl.inc_idx) begin
        idx_r <= idx_r + vtic_pkg::VOLS_W'(1);
      end
      if (ctrl.wr) begin
        slot_r <= vols_r[vtic_pkg::SLOT_W-1:0];
        vols_r <= vols_r + vtic_pkg::VOLS_W'(1);
      end
      if (ctrl.set_status) begin
        status_r <= ctrl.status;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.load_out && !out_busy) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out && !out_busy) begin
      out_status_r <= status_r;
      out_slot_r   <= slot_r;
      out_vols_r   <= vols_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign status       = out_status_r;
  assign slot_index   = out_slot_r;
  assign volume_count = out_vols_r;

endmodule

[hw/rtl/volume_table_insert_overlap_check.sv]
// top level of the volume table insert block with overlap check
// instantiates vtic_seq and vtic_dp, uses vtic_pkg
//
//  channel  direction  payload (tdata, lowest bit first)
//  in_*     slave      first_cylinder[3:0] first_sector[7:4] sector_count[15:8]
//  out_*    master     status[1:0] slot_index[4:2] volume_count[8:5], zero pad[15:9]
//
// one request in flight; the fetch step takes it, the argument step reports bad
// arguments, the room step reports a full table, then the read step reads one table
// entry and the compare step checks it against the request, looping until an overlap
// goes to the report step or the end of the table leads to the insert step and report
// rst_n clears the volume count and the sequencer; table entries are not cleared
// a result still waiting in the output register holds the sequencer at its report
// step, and in_tready stays low until that earlier result leaves
module volume_table_insert_overlap_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // first_cylinder, first_sector, sector_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status, slot_index, volume_count, zero pad
);

  vtic_pkg::ctrl_t   ctrl;
  vtic_pkg::flags_t  flags;
  vtic_pkg::status_t out_status;
  logic [vtic_pkg::SLOT_W-1:0] out_slot;
  logic [vtic_pkg::VOLS_W-1:0] out_vols;

  // microcode sequencer
  vtic_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // datapath and table
  vtic_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .flags          (flags),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .first_cylinder (in_tdata[3:0]),
    .first_sector   (in_tdata[7:4]),
    .sector_count   (in_tdata[15:8]),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .status         (out_status),
    .slot_index     (out_slot),
    .volume_count   (out_vols)
  );

  // result packing
  assign out_tdata = {7'b0, out_vols, out_slot, out_status};

endmodule

[sim/volume_table_checker.sv]
// result checker for the volume table insert block: watches both stream channels
// predicts every reply from its own copy of the volume table and compares
// depends on vtic_pkg for geometry, widths and status codes
module volume_table_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // first_cylinder, first_sector, sector_count
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // status, slot_index, volume_count, zero pad
  output int          mismatches,
  output int          pending,
  output int          checked
);

  typedef struct packed {
    vtic_pkg::status_t                 status;
    logic [vtic_pkg::SLOT_W-1:0]       slot;
    logic [vtic_pkg::VOLS_W-1:0]       count;
  } outcome_t;

  // shadow of the volume table
  logic [vtic_pkg::CYL_W-1:0] vol_cyl [vtic_pkg::MAX_VOLUMES];
  logic [vtic_pkg::SEC_W-1:0] vol_sec [vtic_pkg::MAX_VOLUMES];
  logic [vtic_pkg::CNT_W-1:0] vol_len [vtic_pkg::MAX_VOLUMES];
  int unsigned                vol_count;

  outcome_t queued_outcomes[$];
  int       bad_replies;
  int       replies_seen;

  // apply one create request to the shadow table, return the reply it earns
  function automatic outcome_t insert_outcome(logic [15:0] req);
    int unsigned cyl, sec, len;
    int unsigned new_first, new_last, old_first, old_last;
    outcome_t    res;
    cyl = req[vtic_pkg::CYL_W-1:0];
    sec = req[vtic_pkg::CYL_W+vtic_pkg::SEC_W-1:vtic_pkg::CYL_W];
    len = req[vtic_pkg::ENTRY_W-1:vtic_pkg::CYL_W+vtic_pkg::SEC_W];
    res.status = vtic_pkg::ST_CREATED;
    res.slot   = '0;
    if (cyl == 0 || cyl >= vtic_pkg::CYLINDERS || sec == 0 ||
        sec >= vtic_pkg::SECTORS_PER_CYLINDER ||
        len == 0 || len >= vtic_pkg::CAPACITY) begin
      res.status = vtic_pkg::ST_INVALID;
    end else if (vol_count >= vtic_pkg::MAX_VOLUMES) begin
      res.status = vtic_pkg::ST_FULL;
    end else begin
      // linear sector positions, the end may run past the last cylinder
      new_first = cyl * vtic_pkg::SECTORS_PER_CYLINDER + sec;
      new_last  = new_first + len - 1;
      for (int k = 0; k < vol_count; k++) begin
        old_first = vol_cyl[k] * vtic_pkg::SECTORS_PER_CYLINDER + vol_sec[k];
        old_last  = old_first + vol_len[k] - 1;
        if (!(new_last < old_first || old_last < new_first))
          res.status = vtic_pkg::ST_OVERLAP;
      end
      if (res.status == vtic_pkg::ST_CREATED) begin
        res.slot           = vtic_pkg::SLOT_W'(vol_count);
        vol_cyl[vol_count] = vtic_pkg::CYL_W'(cyl);
        vol_sec[vol_count] = vtic_pkg::SEC_W'(sec);
        vol_len[vol_count] = vtic_pkg::CNT_W'(len);
        vol_count++;
      end
    end
    res.count = vtic_pkg::VOLS_W'(vol_count);
    return res;
  endfunction

  always @(posedge clk) begin
    outcome_t want, got;
    if (!rst_n) begin
      vol_count = 0;
      queued_outcomes.delete();
    end else begin
      // request transaction: predict its reply
      if (in_tvalid && in_tready)
        queued_outcomes.push_back(insert_outcome(in_tdata));

      // reply transaction: compare with the oldest prediction
      if (out_tvalid && out_tready) begin
        got.status = vtic_pkg::status_t'(out_tdata[1:0]);
        got.slot   = out_tdata[4:2];
        got.count  = out_tdata[8:5];
        replies_seen++;
        if (queued_outcomes.size() == 0) begin
          bad_replies++;
          if (bad_replies <= 10)
            $display("unexpected reply %0d: status %0d slot %0d count %0d",
                     replies_seen, got.status, got.slot, got.count);
        end else begin
          want = queued_outcomes.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.count !== want.count) begin
            bad_replies++;
            if (bad_replies <= 10)
              $display("reply %0d mismatch: expected status %0d slot %0d count %0d, %s",
                       replies_seen, want.status, want.slot, want.count,
                       $sformatf("got status %0d slot %0d count %0d",
                                 got.status, got.slot, got.count));
          end
        end
      end
    end
    mismatches <= bad_replies;
    pending    <= queued_outcomes.size();
    checked    <= replies_seen;
  end

endmodule

[sim/tb.sv]
// testbench top for volume_table_insert_overlap_check: clock, reset, request
// stimulus, result sink with random stalls, watchdog and verdict
// depends on vtic_pkg, the block and volume_table_checker
module tb;

  localparam int HOLD_OFF     = 400;   // long receiver stall, fills the block
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES = 40;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [15:0] out_tdata;

  int          mismatches;
  int          pending;
  int          checked;
  int unsigned sent;
  int unsigned idle_cycles = 0;

  always #6 clk = ~clk;

  volume_table_insert_overlap_check dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  volume_table_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // idle cycles before a transaction, with stretches of back-to-back traffic
  function automatic int unsigned draw_wait(int unsigned idx, int unsigned period);
    if ((idx / period) % 3 == 2)
      return 0;
    return $urandom_range(0, 17);
  endfunction

  // offer one create request and hold it until accepted
  task automatic send_request(input int c, input int f, input int n);
    int unsigned gap;
    gap = draw_wait(sent, 120);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {vtic_pkg::CNT_W'(n), vtic_pkg::SEC_W'(f), vtic_pkg::CYL_W'(c)};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result sink: random stalls plus one long hold-off
  initial begin : result_sink
    int unsigned taken;
    int unsigned pause;
    taken = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      pause = (taken == 250) ? HOLD_OFF : draw_wait(taken, 90);
      if (pause > 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  // request stimulus and verdict
  initial begin : request_source
    int c, f, n, pick;
    sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field limits on an empty table
    send_request(0, 5, 10);
    send_request(3, 0, 10);
    send_request(3, 5, 0);
    send_request(0, 0, 0);

    // first volume at 87..119, then an extent ending on its first sector
    send_request(5, 7, 33);
    send_request(3, 12, 28);
    send_request(5, 7, 33);
    send_request(7, 7, 1);

    // fill the disk around it; 47..86 ends just before 87
    send_request(1, 1, 30);
    send_request(2, 15, 40);
    send_request(7, 8, 1);
    send_request(7, 9, 50);
    send_request(11, 1, 40);
    // runs past the last cylinder
    send_request(13, 9, 255);

    // largest fields, and both edges of the remaining hole 171..176
    send_request(15, 15, 255);
    send_request(15, 15, 1);
    send_request(10, 10, 1);
    send_request(10, 11, 7);

    // seven volumes stored, one slot free: hammer the overlap scan
    for (int i = 0; i < 1850; i++) begin
      pick = $urandom_range(0, 99);
      c    = $urandom_range(1, 15);
      f    = $urandom_range(1, 15);
      n    = $urandom_range(1, 255);
      if (pick < 10)
        n = (pick < 5) ? 1 : 255;
      if (pick >= 70 && pick < 80) begin
        // start in the hole but long enough to reach the next volume
        c = 10;
        f = $urandom_range(11, 15);
        n = 18 - f + $urandom_range(0, 40);
      end else if (pick >= 80 && pick < 95) begin
        // one field out of range
        case ($urandom_range(0, 2))
          0:       c = 0;
          1:       f = 0;
          default: n = 0;
        endcase
      end else if (pick >= 95) begin
        c = $urandom_range(0, 15);
        f = $urandom_range(0, 15);
        n = $urandom_range(0, 255);
      end
      // keep the hole closed until the end
      if (c == 10 && f >= 11 && n >= 1 && n <= 17 - f)
        n = n + 18 - f;
      send_request(c, f, n);
    end

    // take the last slot
    f = $urandom_range(11, 15);
    send_request(10, f, $urandom_range(1, 17 - f));

    // full table, invalid fields still win
    send_request(0, 0, 0);
    send_request(15, 15, 255);
    for (int i = 0; i < 40; i++)
      send_request($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 255));
    in_tvalid <= 1'b0;

    // drain outstanding replies
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d create requests sent, %0d replies checked", sent, checked);
    $display("covered field limits, overlap scans over seven volumes, last slot, full table");
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
